FILE: design/kpv_pkg.sv
// kpv_pkg: shared types, constants, op codes and fixed-point helpers
// for the position/velocity kalman filter core; no dependencies
package kpv_pkg;

    // datapath widths
    localparam int WIDE_W   = 72;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIV_W    = 64;
    localparam int QUO_BITS = 31;
    localparam int CFG_AW   = 4;

    // register reset values
    localparam logic [15:0] DT_RESET = 16'd1376;
    localparam logic [30:0] RD_RESET = 31'd104857600;
    localparam logic [30:0] RV_RESET = 31'd167772;
    localparam logic [30:0] Q_RESET  = 31'd604;

    // register indexes
    localparam logic [1:0] REG_DT = 2'd0;
    localparam logic [1:0] REG_RD = 2'd1;
    localparam logic [1:0] REG_RV = 2'd2;
    localparam logic [1:0] REG_Q  = 2'd3;

    localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide SAT_HI = t_wide'(32'sh7fff_ffff);
    localparam t_wide SAT_LO = t_wide'(32'sh8000_0000);

    typedef struct packed {
        logic signed [31:0] accel_in;
        logic signed [31:0] meas_position;
        logic signed [31:0] meas_velocity;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] est_position;
        logic signed [31:0] est_velocity;
        logic               singular;
    } t_out_word;

    typedef struct packed {
        logic [15:0] time_step;
        logic [30:0] position_noise_var;
        logic [30:0] velocity_noise_var;
        logic [30:0] process_noise_var;
    } t_cfg;

    // datapath operations, in sequence order
    typedef enum logic [5:0] {
        OP_DT2, OP_XP0, OP_XP1, OP_XV, OP_P0A, OP_P0B, OP_P0C, OP_P123,
        OP_INIT, OP_SUMS, OP_DET0, OP_DET1, OP_CHK, OP_KEEP,
        OP_N0A, OP_N0B, OP_N1A, OP_N1B, OP_N2A, OP_N2B, OP_N3A, OP_N3B,
        OP_DIV0, OP_DIV1, OP_DIV2, OP_DIV3,
        OP_E0A, OP_E0B, OP_E1A, OP_E1B,
        OP_C0A, OP_C0B, OP_C1A, OP_C1B, OP_C2A, OP_C2B, OP_C3A, OP_C3B,
        OP_FINISH
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       issue;
        t_op        op;
        logic       div_start;
        logic [1:0] div_idx;
        logic       finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic first;
        logic sing;
        logic div_done;
        logic out_free;
    } t_sts;

    function automatic t_wide sx32(input logic signed [31:0] v);
        return t_wide'(v);
    endfunction

    function automatic t_wide ux31(input logic [30:0] v);
        return t_wide'(signed'({1'b0, v}));
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide x);
        if (x > SAT_HI) begin
            return 32'sh7fff_ffff;
        end else if (x < SAT_LO) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // add half an lsb, then arithmetic shift right
    function automatic t_wide rnd(input t_wide x, input int unsigned sh);
        return (x + (t_wide'(1) <<< (sh - 1))) >>> sh;
    endfunction

endpackage

FILE: design/kpv_div.sv
// kpv_div: bit-serial signed divider giving n*2^24/d, truncated, saturated
// to signed 32 bits; depends on kpv_pkg
module kpv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_num_neg,
    input  logic [kpv_pkg::DIV_W-1:0]     i_num_mag,
    input  logic                          i_den_neg,
    input  logic [kpv_pkg::DIV_W-1:0]     i_den_mag,
    output logic                          o_done,
    output logic signed [31:0]            o_quo
);

    localparam int CNT_W = $clog2(kpv_pkg::QUO_BITS + 1);
    localparam int PRE   = 7;

    logic                          r_busy;
    logic                          r_fin;
    logic [CNT_W-1:0]              r_cnt;
    logic [kpv_pkg::DIV_W-1:0]     r_rem;
    logic [kpv_pkg::DIV_W-1:0]     r_den;
    logic [kpv_pkg::QUO_BITS-1:0]  r_bits;
    logic [kpv_pkg::QUO_BITS-1:0]  r_quo;
    logic                          r_neg;
    logic                          r_ovf;

    logic [kpv_pkg::DIV_W:0]       trial;
    logic [kpv_pkg::DIV_W:0]       diff;
    logic                          ge;
    logic                          ovf;
    logic [31:0]                   mag;

    // one quotient bit per cycle
    assign trial = {r_rem, r_bits[kpv_pkg::QUO_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = !diff[kpv_pkg::DIV_W];

    // quotient of 128 or more saturates
    assign ovf = {{PRE{1'b0}}, i_num_mag} >= {i_den_mag, {PRE{1'b0}}};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= !ovf;
                r_fin  <= ovf;
                r_cnt  <= CNT_W'(kpv_pkg::QUO_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {{PRE{1'b0}}, i_num_mag[kpv_pkg::DIV_W-1:PRE]};
            r_bits <= {i_num_mag[PRE-1:0], {(kpv_pkg::QUO_BITS - PRE){1'b0}}};
            r_den  <= i_den_mag;
            r_neg  <= i_num_neg ^ i_den_neg;
            r_ovf  <= ovf;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[kpv_pkg::DIV_W-1:0] : trial[kpv_pkg::DIV_W-1:0];
            r_quo  <= {r_quo[kpv_pkg::QUO_BITS-2:0], ge};
            r_bits <= {r_bits[kpv_pkg::QUO_BITS-2:0], 1'b0};
        end
    end

    // sign and saturation
    always_comb begin
        if (r_ovf) begin
            mag = r_neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            mag = {1'b0, r_quo};
        end
    end

    assign o_quo  = signed'(r_neg ? (~mag + 32'd1) : mag);
    assign o_done = r_fin;

endmodule

FILE: design/kpv_dp.sv
// kpv_dp: filter datapath with shared 33x33 multiplier, writeback stage,
// filter state and output register; depends on kpv_pkg and kpv_div
module kpv_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kpv_pkg::t_cfg       i_cfg,
    input  kpv_pkg::t_cmd       i_cmd,
    output kpv_pkg::t_sts       o_sts,
    input  kpv_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kpv_pkg::t_out_word  o_out_word
);

    // filter state
    logic                     r_first;
    logic signed [31:0]       r_pos;
    logic signed [31:0]       r_vel;
    logic signed [31:0]       r_c [4];

    // working values
    logic signed [31:0]       r_u, r_zp, r_zv;
    logic [31:0]              r_dt2;
    logic [15:0]              r_b0;
    logic signed [31:0]       r_xp, r_xv;
    logic signed [31:0]       r_pp [4];
    logic signed [31:0]       r_s00, r_s11, r_y0, r_y1;
    logic                     r_dneg;
    logic [kpv_pkg::DIV_W-1:0] r_dmag;
    logic                     r_sing;
    logic                     r_nneg [4];
    logic [kpv_pkg::DIV_W-1:0] r_nmag [4];
    logic signed [31:0]       r_k [4];
    logic [1:0]               r_kidx;
    kpv_pkg::t_wide           r_acc;

    // multiplier and writeback stage
    logic signed [kpv_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [kpv_pkg::PROD_W-1:0] r_prod;
    kpv_pkg::t_op             r_wb_op;
    logic                     r_wb_vld;

    logic                     r_ovalid;
    kpv_pkg::t_out_word       r_out;

    logic signed [kpv_pkg::MUL_W-1:0] dt_m, dt2_m, b0_m;
    kpv_pkg::t_wide           prod_w, sum_ap, diff_ap, diff_abs, r16, r24, r32;
    logic [32:0]              b0_sum;
    logic                     div_done;
    logic signed [31:0]       div_quo;

    function automatic logic signed [kpv_pkg::MUL_W-1:0] m32(input logic signed [31:0] v);
        return kpv_pkg::MUL_W'(v);
    endfunction

    assign dt_m  = kpv_pkg::MUL_W'(signed'({1'b0, i_cfg.time_step}));
    assign dt2_m = signed'({1'b0, r_dt2});
    assign b0_m  = kpv_pkg::MUL_W'(signed'({1'b0, r_b0}));

    // operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            kpv_pkg::OP_DT2:  begin mul_a = dt_m;       mul_b = dt_m;       end
            kpv_pkg::OP_XP0:  begin mul_a = dt_m;       mul_b = m32(r_vel); end
            kpv_pkg::OP_XP1:  begin mul_a = b0_m;       mul_b = m32(r_u);   end
            kpv_pkg::OP_XV:   begin mul_a = dt_m;       mul_b = m32(r_u);   end
            kpv_pkg::OP_P0A:  begin mul_a = dt_m;       mul_b = m32(r_c[1]); end
            kpv_pkg::OP_P0B:  begin mul_a = dt_m;       mul_b = m32(r_c[2]); end
            kpv_pkg::OP_P0C:  begin mul_a = dt2_m;      mul_b = m32(r_c[3]); end
            kpv_pkg::OP_P123: begin mul_a = dt_m;       mul_b = m32(r_c[3]); end
            kpv_pkg::OP_DET0: begin mul_a = m32(r_s00); mul_b = m32(r_s11); end
            kpv_pkg::OP_DET1: begin mul_a = m32(r_pp[1]); mul_b = m32(r_pp[2]); end
            kpv_pkg::OP_N0A:  begin mul_a = m32(r_pp[0]); mul_b = m32(r_s11); end
            kpv_pkg::OP_N0B:  begin mul_a = m32(r_pp[1]); mul_b = m32(r_pp[2]); end
            kpv_pkg::OP_N1A:  begin mul_a = m32(r_pp[1]); mul_b = m32(r_s00); end
            kpv_pkg::OP_N1B:  begin mul_a = m32(r_pp[0]); mul_b = m32(r_pp[1]); end
            kpv_pkg::OP_N2A:  begin mul_a = m32(r_pp[2]); mul_b = m32(r_s11); end
            kpv_pkg::OP_N2B:  begin mul_a = m32(r_pp[3]); mul_b = m32(r_pp[2]); end
            kpv_pkg::OP_N3A:  begin mul_a = m32(r_pp[3]); mul_b = m32(r_s00); end
            kpv_pkg::OP_N3B:  begin mul_a = m32(r_pp[2]); mul_b = m32(r_pp[1]); end
            kpv_pkg::OP_E0A:  begin mul_a = m32(r_k[0]); mul_b = m32(r_y0); end
            kpv_pkg::OP_E0B:  begin mul_a = m32(r_k[1]); mul_b = m32(r_y1); end
            kpv_pkg::OP_E1A:  begin mul_a = m32(r_k[2]); mul_b = m32(r_y0); end
            kpv_pkg::OP_E1B:  begin mul_a = m32(r_k[3]); mul_b = m32(r_y1); end
            kpv_pkg::OP_C0A:  begin mul_a = m32(r_k[0]); mul_b = m32(r_pp[0]); end
            kpv_pkg::OP_C0B:  begin mul_a = m32(r_k[1]); mul_b = m32(r_pp[2]); end
            kpv_pkg::OP_C1A:  begin mul_a = m32(r_k[0]); mul_b = m32(r_pp[1]); end
            kpv_pkg::OP_C1B:  begin mul_a = m32(r_k[1]); mul_b = m32(r_pp[3]); end
            kpv_pkg::OP_C2A:  begin mul_a = m32(r_k[2]); mul_b = m32(r_pp[0]); end
            kpv_pkg::OP_C2B:  begin mul_a = m32(r_k[3]); mul_b = m32(r_pp[2]); end
            kpv_pkg::OP_C3A:  begin mul_a = m32(r_k[2]); mul_b = m32(r_pp[1]); end
            kpv_pkg::OP_C3B:  begin mul_a = m32(r_k[3]); mul_b = m32(r_pp[3]); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // writeback arithmetic on the registered product
    assign prod_w   = kpv_pkg::t_wide'(r_prod);
    assign sum_ap   = r_acc + prod_w;
    assign diff_ap  = r_acc - prod_w;
    assign diff_abs = (diff_ap < 0) ? -diff_ap : diff_ap;
    assign r16      = kpv_pkg::rnd(prod_w, 16);
    assign r24      = kpv_pkg::rnd(prod_w, 24);
    assign r32      = kpv_pkg::rnd(prod_w, 32);
    assign b0_sum   = {1'b0, r_prod[31:0]} + 33'h1_0000;

    // gain divider
    kpv_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_num_neg (r_nneg[i_cmd.div_idx]),
        .i_num_mag (r_nmag[i_cmd.div_idx]),
        .i_den_neg (r_dneg),
        .i_den_mag (r_dmag),
        .o_done    (div_done),
        .o_quo     (div_quo)
    );

    // control state, filter state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 1'b1;
            r_pos    <= '0;
            r_vel    <= '0;
            r_c[0]   <= kpv_pkg::ONE_Q24;
            r_c[1]   <= '0;
            r_c[2]   <= '0;
            r_c[3]   <= kpv_pkg::ONE_Q24;
            r_wb_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.issue;
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
                r_first  <= 1'b0;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (r_wb_vld) begin
                case (r_wb_op)
                    kpv_pkg::OP_KEEP: begin
                        r_pos <= r_xp;
                        r_vel <= r_xv;
                        for (int i = 0; i < 4; i++) r_c[i] <= r_pp[i];
                    end
                    kpv_pkg::OP_E0B:
                        r_pos <= kpv_pkg::sat32(kpv_pkg::sx32(r_xp) + r_acc + r24);
                    kpv_pkg::OP_E1B:
                        r_vel <= kpv_pkg::sat32(kpv_pkg::sx32(r_xv) + r_acc + r24);
                    kpv_pkg::OP_C0B:
                        r_c[0] <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[0]) - r_acc - r24);
                    kpv_pkg::OP_C1B:
                        r_c[1] <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[1]) - r_acc - r24);
                    kpv_pkg::OP_C2B:
                        r_c[2] <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[2]) - r_acc - r24);
                    kpv_pkg::OP_C3B:
                        r_c[3] <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[3]) - r_acc - r24);
                    default: ;
                endcase
            end
        end
    end

    // multiplier stage, input capture, working values and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_prod  <= mul_a * mul_b;
            r_wb_op <= i_cmd.op;
        end
        if (i_cmd.accept) begin
            r_u  <= i_in_word.accel_in;
            r_zp <= i_in_word.meas_position;
            r_zv <= i_in_word.meas_velocity;
        end
        if (i_cmd.div_start) begin
            r_kidx <= i_cmd.div_idx;
        end
        if (div_done) begin
            r_k[r_kidx] <= div_quo;
        end
        if (i_cmd.finish) begin
            r_out.est_position <= r_pos;
            r_out.est_velocity <= r_vel;
            r_out.singular     <= r_sing;
        end
        if (r_wb_vld) begin
            case (r_wb_op)
                kpv_pkg::OP_DT2: begin
                    r_dt2 <= r_prod[31:0];
                    r_b0  <= b0_sum[32:17];
                end
                kpv_pkg::OP_XP0, kpv_pkg::OP_P0A, kpv_pkg::OP_DET0,
                kpv_pkg::OP_N0A, kpv_pkg::OP_N1A, kpv_pkg::OP_N2A, kpv_pkg::OP_N3A:
                    r_acc <= prod_w;
                kpv_pkg::OP_XP1:
                    r_xp <= kpv_pkg::sat32(kpv_pkg::sx32(r_pos) + kpv_pkg::rnd(sum_ap, 16));
                kpv_pkg::OP_XV:
                    r_xv <= kpv_pkg::sat32(kpv_pkg::sx32(r_vel) + r16);
                kpv_pkg::OP_P0B:
                    r_acc <= kpv_pkg::rnd(sum_ap, 16) + kpv_pkg::sx32(r_c[0])
                             + kpv_pkg::ux31(i_cfg.process_noise_var);
                kpv_pkg::OP_P0C:
                    r_pp[0] <= kpv_pkg::sat32(r_acc + r32);
                kpv_pkg::OP_P123: begin
                    r_pp[1] <= kpv_pkg::sat32(kpv_pkg::sx32(r_c[1]) + r16);
                    r_pp[2] <= kpv_pkg::sat32(kpv_pkg::sx32(r_c[2]) + r16);
                    r_pp[3] <= kpv_pkg::sat32(kpv_pkg::sx32(r_c[3])
                                              + kpv_pkg::ux31(i_cfg.process_noise_var));
                end
                kpv_pkg::OP_INIT: begin
                    r_xp    <= r_zp;
                    r_xv    <= r_zv;
                    r_pp[0] <= kpv_pkg::ONE_Q24;
                    r_pp[1] <= '0;
                    r_pp[2] <= '0;
                    r_pp[3] <= kpv_pkg::ONE_Q24;
                end
                kpv_pkg::OP_SUMS: begin
                    r_s00 <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[0])
                                            + kpv_pkg::ux31(i_cfg.position_noise_var));
                    r_s11 <= kpv_pkg::sat32(kpv_pkg::sx32(r_pp[3])
                                            + kpv_pkg::ux31(i_cfg.velocity_noise_var));
                    r_y0  <= kpv_pkg::sat32(kpv_pkg::sx32(r_zp) - kpv_pkg::sx32(r_xp));
                    r_y1  <= kpv_pkg::sat32(kpv_pkg::sx32(r_zv) - kpv_pkg::sx32(r_xv));
                end
                kpv_pkg::OP_DET1: begin
                    r_dneg <= diff_ap < 0;
                    r_dmag <= diff_abs[kpv_pkg::DIV_W-1:0];
                    r_sing <= diff_ap == 0;
                end
                kpv_pkg::OP_N0B: begin
                    r_nneg[0] <= diff_ap < 0;
                    r_nmag[0] <= diff_abs[kpv_pkg::DIV_W-1:0];
                end
                kpv_pkg::OP_N1B: begin
                    r_nneg[1] <= diff_ap < 0;
                    r_nmag[1] <= diff_abs[kpv_pkg::DIV_W-1:0];
                end
                kpv_pkg::OP_N2B: begin
                    r_nneg[2] <= diff_ap < 0;
                    r_nmag[2] <= diff_abs[kpv_pkg::DIV_W-1:0];
                end
                kpv_pkg::OP_N3B: begin
                    r_nneg[3] <= diff_ap < 0;
                    r_nmag[3] <= diff_abs[kpv_pkg::DIV_W-1:0];
                end
                kpv_pkg::OP_E0A, kpv_pkg::OP_E1A, kpv_pkg::OP_C0A,
                kpv_pkg::OP_C1A, kpv_pkg::OP_C2A, kpv_pkg::OP_C3A:
                    r_acc <= r24;
                default: ;
            endcase
        end
    end

    // status
    assign o_sts.first    = r_first;
    assign o_sts.sing     = r_sing;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // a new word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_ovalid || !i_out_stall))
        else $error("output word overwritten while stalled");

    // ops are spaced so each writeback finishes before the next issue
    a_op_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> !i_cmd.issue)
        else $error("op issued during writeback");

    // gain result arrives only while the multiplier is quiet
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (!i_cmd.issue && !r_wb_vld && !i_cmd.div_start))
        else $error("divider done overlaps other work");
`endif

endmodule

FILE: design/kpv_ctrl.sv
// kpv_ctrl: sequencer that steps the datapath through predict, gain and
// update ops for one word; depends on kpv_pkg
module kpv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  kpv_pkg::t_sts  i_sts,
    output kpv_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WB, ST_DIV} t_state;

    t_state        r_state, n_state;
    kpv_pkg::t_op  r_op, n_op;

    // op that follows in the sequence
    function automatic kpv_pkg::t_op next_op(input kpv_pkg::t_op op);
        case (op)
            kpv_pkg::OP_P123: return kpv_pkg::OP_SUMS;
            kpv_pkg::OP_INIT: return kpv_pkg::OP_SUMS;
            kpv_pkg::OP_KEEP: return kpv_pkg::OP_FINISH;
            default:          return kpv_pkg::t_op'(6'(op + 1));
        endcase
    endfunction

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_op    = i_sts.first ? kpv_pkg::OP_INIT : kpv_pkg::OP_DT2;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                case (r_op)
                    kpv_pkg::OP_CHK:
                        n_op = i_sts.sing ? kpv_pkg::OP_KEEP : kpv_pkg::OP_N0A;
                    kpv_pkg::OP_DIV0: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_idx   = 2'd0;
                        n_state = ST_DIV;
                    end
                    kpv_pkg::OP_DIV1: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_idx   = 2'd1;
                        n_state = ST_DIV;
                    end
                    kpv_pkg::OP_DIV2: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_idx   = 2'd2;
                        n_state = ST_DIV;
                    end
                    kpv_pkg::OP_DIV3: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_idx   = 2'd3;
                        n_state = ST_DIV;
                    end
                    kpv_pkg::OP_FINISH: begin
                        if (i_sts.out_free) begin
                            o_cmd.finish = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.issue = 1'b1;
                        n_state = ST_WB;
                    end
                endcase
            end
            ST_WB: begin
                n_op    = next_op(r_op);
                n_state = ST_ISSUE;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_op    = next_op(r_op);
                    n_state = ST_ISSUE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= kpv_pkg::OP_DT2;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: design/kalman_position_velocity_core.sv
// two-state position/velocity kalman filter, fixed point
//
// input channel (i_in_valid / o_in_stall / i_in_word) takes one word of
// acceleration, measured position and measured velocity, all signed
// q16.16. output channel (o_out_valid / i_out_stall / o_out_word) gives one
// word per input: updated position and velocity, q16.16 saturated, and a
// singular flag when the innovation covariance could not be inverted.
// the first word after reset seeds the estimate from the measurement.
// one word is processed at a time: o_in_stall is high from accept until
// the result is loaded into the output register. the time per word is set
// by the shared multiplier and the bit-serial divider; the seeding word
// skips the predict ops, a saturating gain ends its division early, and a
// singular word skips the divider. the output register frees the sequencer,
// so the next word can be taken while a result waits; if the receiver
// stalls with a result waiting, the following result holds in the sequencer
// until that one is taken.
// reset (synchronous, active low) restores registers, identity covariance,
// zero estimate and the seed-from-measurement mode; no clearing pass.
// configuration is written over the apb port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module kalman_position_velocity_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  kpv_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output kpv_pkg::t_out_word              o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kpv_pkg::CFG_AW-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    kpv_pkg::t_cfg  r_cfg;
    kpv_pkg::t_cmd  cmd;
    kpv_pkg::t_sts  sts;
    logic           cfg_wr;
    logic [1:0]     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step          <= kpv_pkg::DT_RESET;
            r_cfg.position_noise_var <= kpv_pkg::RD_RESET;
            r_cfg.velocity_noise_var <= kpv_pkg::RV_RESET;
            r_cfg.process_noise_var  <= kpv_pkg::Q_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                kpv_pkg::REG_DT: r_cfg.time_step          <= pwdata[15:0];
                kpv_pkg::REG_RD: r_cfg.position_noise_var <= pwdata[30:0];
                kpv_pkg::REG_RV: r_cfg.velocity_noise_var <= pwdata[30:0];
                kpv_pkg::REG_Q:  r_cfg.process_noise_var  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            kpv_pkg::REG_DT: prdata = {16'd0, r_cfg.time_step};
            kpv_pkg::REG_RD: prdata = {1'b0, r_cfg.position_noise_var};
            kpv_pkg::REG_RV: prdata = {1'b0, r_cfg.velocity_noise_var};
            kpv_pkg::REG_Q:  prdata = {1'b0, r_cfg.process_noise_var};
            default:         prdata = '0;
        endcase
    end

    kpv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kpv_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: test/testbench.sv
// testbench for kalman_position_velocity_core: drives measurement words,
// predicts each filter result in fixed point and checks the output channel
// depends on kpv_pkg and the core rtl only
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    kpv_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    kpv_pkg::t_out_word o_out_word;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [kpv_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kalman_position_velocity_core dut (.*);

    always #10 i_clk = ~i_clk;

    // filter state held by the predictor
    logic [15:0] cur_dt;
    longint cur_rd, cur_rv, cur_q;
    bit seed_next;
    longint est_pos, est_vel;
    longint cov [4];

    kpv_pkg::t_out_word pending_words [$];
    int err_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    function automatic longint asr(longint x, int sh);
        return x >>> sh;
    endfunction

    function automatic longint round_shift(longint x, int sh);
        return asr(x + (longint'(1) << (sh - 1)), sh);
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // gain numerator*2^24/det: truncated toward zero, clamped
    function automatic longint gain_q24(longint nhi, longint nlo, longint dhi, longint dlo);
        logic signed [127:0] n, d, qv, mag;
        n = 128'(nhi) - 128'(nlo);
        d = 128'(dhi) - 128'(dlo);
        mag = (n < 0) ? -n : n;
        qv = (mag << 24) / ((d < 0) ? -d : d);
        if ((n < 0) != (d < 0)) begin
            if (qv > 128'sd2147483648) qv = 128'sd2147483648;
            return -longint'(qv);
        end
        if (qv > 128'sd2147483647) qv = 128'sd2147483647;
        return longint'(qv);
    endfunction

    function automatic void filter_reset();
        cur_dt = kpv_pkg::DT_RESET;
        cur_rd = kpv_pkg::RD_RESET;
        cur_rv = kpv_pkg::RV_RESET;
        cur_q = kpv_pkg::Q_RESET;
        seed_next = 1'b1;
        est_pos = 0;
        est_vel = 0;
        cov = '{64'sd16777216, 0, 0, 64'sd16777216};
    endfunction

    // one filter step: predict, update, return expected word
    function automatic kpv_pkg::t_out_word filter_step(kpv_pkg::t_in_word w);
        longint u, zp, zv, xp, xv, dt, dt2, b0;
        longint p [4];
        longint k [4];
        longint s00, s11, y0, y1, ep, ev;
        logic signed [127:0] dhi, dlo;
        kpv_pkg::t_out_word r;
        u = w.accel_in;
        zp = w.meas_position;
        zv = w.meas_velocity;
        if (seed_next) begin
            xp = zp;
            xv = zv;
            p = '{64'sd16777216, 0, 0, 64'sd16777216};
        end else begin
            dt = cur_dt;
            dt2 = dt * dt;
            b0 = (dt2 + 65536) >> 17;
            xp = clamp32(est_pos + round_shift(dt * est_vel + b0 * u, 16));
            xv = clamp32(est_vel + round_shift(dt * u, 16));
            p[0] = clamp32(cov[0] + round_shift(dt * (cov[1] + cov[2]), 16)
                           + round_shift(dt2 * cov[3], 32) + cur_q);
            p[1] = clamp32(cov[1] + round_shift(dt * cov[3], 16));
            p[2] = clamp32(cov[2] + round_shift(dt * cov[3], 16));
            p[3] = clamp32(cov[3] + cur_q);
        end
        s00 = clamp32(p[0] + cur_rd);
        s11 = clamp32(p[3] + cur_rv);
        dhi = 128'(s00) * 128'(s11);
        dlo = 128'(p[1]) * 128'(p[2]);
        r.singular = (dhi == dlo);
        if (r.singular) begin
            ep = xp;
            ev = xv;
        end else begin
            k[0] = gain_q24(p[0] * s11, p[1] * p[2], longint'(dhi), longint'(dlo));
            k[1] = gain_q24(p[1] * s00, p[0] * p[1], longint'(dhi), longint'(dlo));
            k[2] = gain_q24(p[2] * s11, p[3] * p[2], longint'(dhi), longint'(dlo));
            k[3] = gain_q24(p[3] * s00, p[2] * p[1], longint'(dhi), longint'(dlo));
            y0 = clamp32(zp - xp);
            y1 = clamp32(zv - xv);
            ep = clamp32(xp + round_shift(k[0] * y0, 24) + round_shift(k[1] * y1, 24));
            ev = clamp32(xv + round_shift(k[2] * y0, 24) + round_shift(k[3] * y1, 24));
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    cov[i * 2 + j] = clamp32(p[i * 2 + j]
                        - round_shift(k[i * 2] * p[j], 24)
                        - round_shift(k[i * 2 + 1] * p[2 + j], 24));
                end
            end
        end
        if (r.singular) cov = p;
        est_pos = ep;
        est_vel = ev;
        seed_next = 1'b0;
        r.est_position = ep[31:0];
        r.est_velocity = ev[31:0];
        return r;
    endfunction

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // check each result word
    always @(posedge i_clk) begin
        kpv_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected");
                err_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_out_word.est_position !== want.est_position) begin
                    $error("est_position expected %0d actual %0d",
                           want.est_position, o_out_word.est_position);
                    err_count++;
                end
                if (o_out_word.est_velocity !== want.est_velocity) begin
                    $error("est_velocity expected %0d actual %0d",
                           want.est_velocity, o_out_word.est_velocity);
                    err_count++;
                end
                if (o_out_word.singular !== want.singular) begin
                    $error("singular expected %0d actual %0d",
                           want.singular, o_out_word.singular);
                    err_count++;
                end
            end
        end
    end

    // valid stays up after accept until the next word, an idle cycle or a drain
    task automatic send_word(kpv_pkg::t_in_word w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_words.push_back(filter_step(w));
    endtask

    task automatic wait_drained();
        if (i_in_valid) i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= kpv_pkg::CFG_AW'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            kpv_pkg::REG_DT: cur_dt = val[15:0];
            kpv_pkg::REG_RD: cur_rd = val[30:0];
            kpv_pkg::REG_RV: cur_rv = val[30:0];
            kpv_pkg::REG_Q: cur_q = val[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic kpv_pkg::t_in_word rand_word(bit wild);
        kpv_pkg::t_in_word w;
        if (wild) begin
            w = {$urandom, $urandom, $urandom};
        end else begin
            w.accel_in = $signed($urandom_range(262144)) - 131072;
            w.meas_position = $signed($urandom_range(2097152)) - 1048576;
            w.meas_velocity = $signed($urandom_range(524288)) - 262144;
        end
        return w;
    endfunction

    // extremes, seeding word, zero step, singular covariance
    task automatic test_directed();
        kpv_pkg::t_in_word w;
        send_word('{32'sd65536, 32'sd100000, 32'sd2000});
        send_word('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
        send_word('{32'sh80000000, 32'sh80000000, 32'sh80000000});
        send_word('{0, 32'sh80000000, 32'sh7fffffff});
        send_word('{32'shffffffff, 32'shffffffff, 0});
        wait_drained();
        write_reg(kpv_pkg::REG_DT, 32'd0);
        write_reg(kpv_pkg::REG_RD, 32'h7fffffff);
        write_reg(kpv_pkg::REG_RV, 32'h7fffffff);
        write_reg(kpv_pkg::REG_Q, 32'h7fffffff);
        for (int i = 0; i < 4; i++) send_word(rand_word(1));
        wait_drained();
        // zero noise drives p+r toward zero so the inverse fails
        write_reg(kpv_pkg::REG_DT, 32'hffff);
        write_reg(kpv_pkg::REG_RD, 32'd0);
        write_reg(kpv_pkg::REG_RV, 32'd0);
        write_reg(kpv_pkg::REG_Q, 32'd0);
        for (int i = 0; i < 6; i++) send_word(rand_word(i[0]));
        wait_drained();
        write_reg(kpv_pkg::REG_DT, 32'd1);
        write_reg(kpv_pkg::REG_Q, 32'h0);
        write_reg(kpv_pkg::REG_RD, 32'h01000000);
        write_reg(kpv_pkg::REG_RV, 32'h01000000);
        for (int i = 0; i < 5; i++) send_word(rand_word(0));
        wait_drained();
    endtask

    // random words through idle and stall phases, settings changed between
    task automatic test_random();
        int phase_pct [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{18, 18}};
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            write_reg(kpv_pkg::REG_DT, (ph == 7) ? 32'hffff : $urandom_range(4000, 1));
            write_reg(kpv_pkg::REG_RD, $urandom_range(32'h7fffffff));
            write_reg(kpv_pkg::REG_RV, $urandom_range(32'h3ffffff));
            write_reg(kpv_pkg::REG_Q, (ph == 6) ? 32'h7fffffff : $urandom_range(100000));
            send_idle_pct = phase_pct[ph % 4][0];
            stall_pct = phase_pct[ph % 4][1];
            for (int i = 0; i < 72; i++) begin
                send_word(rand_word($urandom_range(9) == 0));
                if (i == 30) wait_drained();
            end
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        filter_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        wait_drained();
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: kalman_position_velocity_core.f
design/kpv_pkg.sv
design/kpv_div.sv
design/kpv_dp.sv
design/kpv_ctrl.sv
design/kalman_position_velocity_core.sv
test/testbench.sv
